// File: design/msw_pkg.sv
// shared types, constants and table function for the multi-shape wave adder
package msw_pkg;

    localparam int INDEX_BITS_DEF  = 20;
    localparam int TABLE_BITS_DEF  = 10;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int PHASE_BITS = 32;
    localparam int AMP_BITS   = 15;
    localparam int MAG_BITS   = 16;
    localparam int FRAC_BITS  = 15;
    localparam int PROD_BITS  = AMP_BITS + MAG_BITS;
    localparam int WAVE_BITS  = 16;
    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;

    localparam logic [MAG_BITS-1:0] MAG_FULL = 16'h8000;
    localparam logic [PROD_BITS:0] ROUND_HALF = 32'd16384;

    localparam logic [2:0] REG_WAVE_SHAPE   = 3'd0;
    localparam logic [2:0] REG_AMPLITUDE    = 3'd1;
    localparam logic [2:0] REG_PHASE_STEP   = 3'd2;
    localparam logic [2:0] REG_PHASE_OFFSET = 3'd3;
    localparam logic [2:0] REG_START_INDEX  = 3'd4;
    localparam logic [2:0] REG_END_INDEX    = 3'd5;

    localparam logic [63:0] Q30_C1 = 64'd1686629713;
    localparam logic [63:0] Q30_C3 = 64'd693598668;
    localparam logic [63:0] Q30_C5 = 64'd85569306;
    localparam logic [63:0] Q30_C7 = 64'd5026995;
    localparam logic [63:0] Q30_C9 = 64'd172272;

    typedef enum logic [1:0] {
        SHAPE_SINE   = 2'd0,
        SHAPE_TRI    = 2'd1,
        SHAPE_SQUARE = 2'd2,
        SHAPE_NONE   = 2'd3
    } shape_t;

    typedef struct packed {
        shape_t                wave_shape;
        logic [AMP_BITS-1:0]   amplitude;
        logic [PHASE_BITS-1:0] phase_step;
        logic [PHASE_BITS-1:0] phase_offset;
    } cfg_t;

    // quarter-wave sine entry, odd taylor polynomial in unsigned q30
    function automatic logic [MAG_BITS-1:0] quarter_entry(input int unsigned k,
                                                          input int unsigned table_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] r;
        x  = ((64'(k) << 1) + 64'd1) << (29 - table_bits);
        x2 = (x * x) >> 30;
        r  = Q30_C7 - ((x2 * Q30_C9) >> 30);
        r  = Q30_C5 - ((x2 * r) >> 30);
        r  = Q30_C3 - ((x2 * r) >> 30);
        r  = Q30_C1 - ((x2 * r) >> 30);
        r  = (x * r) >> 30;
        r  = (r + 64'd16384) >> 15;
        return r[MAG_BITS-1:0];
    endfunction

endpackage

// File: design/msw_cfg.sv
// apb configuration registers
module msw_cfg #(
    parameter int INDEX_BITS = msw_pkg::INDEX_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [msw_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [msw_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [msw_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    output msw_pkg::cfg_t                       cfg,
    output logic [INDEX_BITS-1:0]               start_index,
    output logic [INDEX_BITS:0]                 end_index
);

    msw_pkg::cfg_t           cfg_reg;
    logic [INDEX_BITS-1:0]   start_reg;
    logic [INDEX_BITS:0]     end_reg;
    logic                    wr_en;
    logic [2:0]              reg_sel;
    logic [63:0]             wdata_ext;
    logic [63:0]             start_ext;
    logic [63:0]             end_ext;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite & pready;
    assign reg_sel   = paddr[4:2];
    assign wdata_ext = {32'd0, pwdata};
    assign start_ext = 64'(start_reg);
    assign end_ext   = 64'(end_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wave_shape   <= msw_pkg::SHAPE_NONE;
            cfg_reg.amplitude    <= '0;
            cfg_reg.phase_step   <= '0;
            cfg_reg.phase_offset <= '0;
            start_reg            <= '0;
            end_reg              <= '0;
        end else if (wr_en) begin
            case (reg_sel)
                msw_pkg::REG_WAVE_SHAPE:   cfg_reg.wave_shape   <= msw_pkg::shape_t'(pwdata[1:0]);
                msw_pkg::REG_AMPLITUDE:    cfg_reg.amplitude    <= pwdata[msw_pkg::AMP_BITS-1:0];
                msw_pkg::REG_PHASE_STEP:   cfg_reg.phase_step   <= pwdata;
                msw_pkg::REG_PHASE_OFFSET: cfg_reg.phase_offset <= pwdata;
                msw_pkg::REG_START_INDEX:  start_reg            <= wdata_ext[INDEX_BITS-1:0];
                msw_pkg::REG_END_INDEX:    end_reg              <= wdata_ext[INDEX_BITS:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            msw_pkg::REG_WAVE_SHAPE:   prdata = {30'd0, cfg_reg.wave_shape};
            msw_pkg::REG_AMPLITUDE:    prdata = {17'd0, cfg_reg.amplitude};
            msw_pkg::REG_PHASE_STEP:   prdata = cfg_reg.phase_step;
            msw_pkg::REG_PHASE_OFFSET: prdata = cfg_reg.phase_offset;
            msw_pkg::REG_START_INDEX:  prdata = start_ext[31:0];
            msw_pkg::REG_END_INDEX:    prdata = end_ext[31:0];
            default:                   prdata = '0;
        endcase
    end

    assign cfg         = cfg_reg;
    assign start_index = start_reg;
    assign end_index   = end_reg;

endmodule

// File: design/msw_phase_gen.sv
// sample counter, window test and phase accumulator
module msw_phase_gen #(
    parameter int INDEX_BITS = msw_pkg::INDEX_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              advance,
    input  logic                              accept,
    input  logic                              first_of_frame,
    input  msw_pkg::cfg_t                     cfg,
    input  logic [INDEX_BITS-1:0]             start_index,
    input  logic [INDEX_BITS:0]               end_index,
    output logic [msw_pkg::PHASE_BITS-1:0]    phase,
    output logic                              in_window
);

    logic [INDEX_BITS-1:0]            counter_reg;
    logic [INDEX_BITS-1:0]            counter_next;
    logic [msw_pkg::PHASE_BITS-1:0]   acc_reg;
    logic [msw_pkg::PHASE_BITS-1:0]   acc_next;
    logic                             win_reg;
    logic [INDEX_BITS-1:0]            idx;
    logic                             win;

    assign idx = first_of_frame ? '0 : counter_reg;
    assign win = (idx >= start_index) && ({1'b0, idx} < end_index);

    always_comb begin
        counter_next = counter_reg;
        acc_next     = acc_reg;
        if (accept) begin
            counter_next = idx + 1'b1;
            if (win) begin
                acc_next = (idx == start_index) ? cfg.phase_offset
                                                : acc_reg + cfg.phase_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg <= '0;
            acc_reg     <= '0;
        end else begin
            counter_reg <= counter_next;
            acc_reg     <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            win_reg <= accept & win;
        end
    end

    assign phase     = acc_reg;
    assign in_window = win_reg;

endmodule

// File: design/msw_shape_scale.sv
// sine rom lookup, shape select and amplitude multiply
module msw_shape_scale #(
    parameter int TABLE_BITS = msw_pkg::TABLE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              advance,
    input  logic [msw_pkg::PHASE_BITS-1:0]    phase,
    input  logic                              in_window,
    input  msw_pkg::cfg_t                     cfg,
    output logic [msw_pkg::PROD_BITS-1:0]     product,
    output logic                              negative
);

    localparam int TABLE_SIZE = 1 << TABLE_BITS;

    logic [msw_pkg::MAG_BITS-1:0]   rom [TABLE_SIZE];
    logic [TABLE_BITS-1:0]          rom_addr;
    logic [msw_pkg::MAG_BITS-1:0]   rom_data_reg;
    logic [1:0]                     quad_reg;
    logic [msw_pkg::FRAC_BITS-1:0]  frac_reg;
    logic                           win_reg;
    msw_pkg::shape_t                shape_reg;
    logic [msw_pkg::MAG_BITS-1:0]   mag;
    logic [msw_pkg::PROD_BITS-1:0]  prod_reg;
    logic                           neg_reg;

    for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_rom
        assign rom[g] = msw_pkg::quarter_entry(g, TABLE_BITS);
    end

    // odd quadrants read the table mirrored
    assign rom_addr = phase[30] ? ~phase[29 -: TABLE_BITS] : phase[29 -: TABLE_BITS];

    always_ff @(posedge aclk) begin
        if (advance) begin
            rom_data_reg <= rom[rom_addr];
            quad_reg     <= phase[31:30];
            frac_reg     <= phase[29 -: msw_pkg::FRAC_BITS];
            win_reg      <= in_window;
            shape_reg    <= cfg.wave_shape;
        end
    end

    always_comb begin
        case (shape_reg)
            msw_pkg::SHAPE_SINE:   mag = rom_data_reg;
            msw_pkg::SHAPE_TRI:    mag = quad_reg[0] ? (msw_pkg::MAG_FULL - {1'b0, frac_reg})
                                                     : {1'b0, frac_reg};
            msw_pkg::SHAPE_SQUARE: mag = msw_pkg::MAG_FULL;
            default:               mag = '0;
        endcase
        if (!win_reg) begin
            mag = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_reg <= msw_pkg::PROD_BITS'(cfg.amplitude) * msw_pkg::PROD_BITS'(mag);
            neg_reg  <= quad_reg[1];
        end
    end

    assign product  = prod_reg;
    assign negative = neg_reg;

endmodule

// File: design/msw_mix.sv
// rounding, add to or subtract from sample, saturation and output register
module msw_mix #(
    parameter int SAMPLE_BITS = msw_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              advance,
    input  logic                              in_valid,
    input  logic signed [SAMPLE_BITS-1:0]     sample,
    input  logic [msw_pkg::PROD_BITS-1:0]     product,
    input  logic                              negative,
    output logic                              out_valid,
    output logic [SAMPLE_BITS-1:0]            sample_out,
    output logic                              clipped
);

    localparam int WIDE_BITS = (SAMPLE_BITS > msw_pkg::WAVE_BITS) ? SAMPLE_BITS
                                                                  : msw_pkg::WAVE_BITS;
    localparam int SUM_BITS  = WIDE_BITS + 1;
    localparam logic signed [SUM_BITS-1:0] SAT_MAX =
        SUM_BITS'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    localparam logic signed [SUM_BITS-1:0] SAT_MIN = -SAT_MAX - 1;

    logic [msw_pkg::PROD_BITS:0]     rounded;
    logic [msw_pkg::WAVE_BITS-1:0]   wave;
    logic signed [SUM_BITS-1:0]      wave_ext;
    logic signed [SUM_BITS-1:0]      sum;
    logic [SAMPLE_BITS-1:0]          sat;
    logic                            clip;
    logic                            valid_reg;
    logic [SAMPLE_BITS-1:0]          data_reg;
    logic                            clip_reg;

    assign rounded  = {1'b0, product} + msw_pkg::ROUND_HALF;
    assign wave     = rounded[msw_pkg::FRAC_BITS +: msw_pkg::WAVE_BITS];
    assign wave_ext = $signed(SUM_BITS'(wave));
    assign sum      = negative ? (SUM_BITS'(sample) - wave_ext) : (SUM_BITS'(sample) + wave_ext);

    always_comb begin
        clip = 1'b0;
        sat  = sum[SAMPLE_BITS-1:0];
        if (sum > SAT_MAX) begin
            clip = 1'b1;
            sat  = SAT_MAX[SAMPLE_BITS-1:0];
        end else if (sum < SAT_MIN) begin
            clip = 1'b1;
            sat  = SAT_MIN[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= sat;
            clip_reg <= clip;
        end
    end

    assign out_valid  = valid_reg;
    assign sample_out = data_reg;
    assign clipped    = clip_reg;

endmodule

// File: design/multi_shape_wave_adder_top.sv
// top level: wave adder stream pipeline with apb configuration
// an accepted request passes the phase, table, product and output registers before it is valid on the m_ side
// throughput: one request per cycle while the m_ side does not stall, set by the counter and phase update
// the sine table is a rom read in its own stage; the multiply has a stage of its own
// aresetn is synchronous and active low; it clears the pipeline valid flags, counter, phase
// and registers (wave_shape resets to none, the others to zero)
module multi_shape_wave_adder_top #(
    parameter int INDEX_BITS  = msw_pkg::INDEX_BITS_DEF,
    parameter int TABLE_BITS  = msw_pkg::TABLE_BITS_DEF,
    parameter int SAMPLE_BITS = msw_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,   // sample_in
    input  logic [0:0]                            s_tuser,   // first_of_frame
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,   // sample_out
    output logic [0:0]                            m_tuser,   // clipped
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [msw_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [msw_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [msw_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                  pready
);

    localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    msw_pkg::cfg_t                    cfg;
    logic [INDEX_BITS-1:0]            start_index;
    logic [INDEX_BITS:0]              end_index;
    logic                             advance;
    logic                             accept;
    logic [msw_pkg::PHASE_BITS-1:0]   phase;
    logic                             in_window;
    logic [msw_pkg::PROD_BITS-1:0]    product;
    logic                             negative;
    logic                             v1_reg;
    logic                             v2_reg;
    logic                             v3_reg;
    logic [SAMPLE_BITS-1:0]           sample1_reg;
    logic [SAMPLE_BITS-1:0]           sample2_reg;
    logic [SAMPLE_BITS-1:0]           sample3_reg;
    logic                             out_valid;
    logic [SAMPLE_BITS-1:0]           sample_out;
    logic                             clipped;

    assign advance  = !out_valid || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    msw_cfg #(
        .INDEX_BITS (INDEX_BITS)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .cfg         (cfg),
        .start_index (start_index),
        .end_index   (end_index)
    );

    msw_phase_gen #(
        .INDEX_BITS (INDEX_BITS)
    ) u_phase_gen (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .accept         (accept),
        .first_of_frame (s_tuser[0]),
        .cfg            (cfg),
        .start_index    (start_index),
        .end_index      (end_index),
        .phase          (phase),
        .in_window      (in_window)
    );

    msw_shape_scale #(
        .TABLE_BITS (TABLE_BITS)
    ) u_shape_scale (
        .aclk      (aclk),
        .advance   (advance),
        .phase     (phase),
        .in_window (in_window),
        .cfg       (cfg),
        .product   (product),
        .negative  (negative)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sample1_reg <= s_tdata[SAMPLE_BITS-1:0];
            sample2_reg <= sample1_reg;
            sample3_reg <= sample2_reg;
        end
    end

    msw_mix #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mix (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .in_valid   (v3_reg),
        .sample     ($signed(sample3_reg)),
        .product    (product),
        .negative   (negative),
        .out_valid  (out_valid),
        .sample_out (sample_out),
        .clipped    (clipped)
    );

    assign m_tvalid   = out_valid;
    assign m_tdata    = TDATA_BITS'(sample_out);
    assign m_tuser[0] = clipped;

`ifndef SYNTHESIS
    localparam logic [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // a clipped result sits on one of the two limits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            (m_tdata[SAMPLE_BITS-1:0] == OUT_MAX) || (m_tdata[SAMPLE_BITS-1:0] == OUT_MIN))
        else $error("clipped result not at a saturation limit");

    // frame start inside a window that opens at zero loads the phase offset
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tuser[0] && (start_index == '0) && (end_index != '0) |=>
            phase == $past(cfg.phase_offset))
        else $error("phase not loaded with offset at window start");

    // the window flag is only set with a request in the first stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        !v1_reg |-> !in_window)
        else $error("window flag set without an item in flight");
`endif

endmodule
